### rtl/fcma_pkg.sv
// Shared types and constants for the four-channel moving average block.
`default_nettype none

package fcma_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int CHANNELS = 4;
    localparam int COUNT_W  = 6;
    localparam int RING_W   = SAMPLE_W * CHANNELS;

    // Divider: quotient bits, divisor 2*n, partial remainder
    localparam int QUO_W    = 16;
    localparam int DEN_W    = COUNT_W + 1;
    localparam int REM_W    = DEN_W + 1;
    localparam int STEP_W   = 5;

    // Window length after reset
    localparam int WL_RESET = 5;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch sample, read oldest ring entry
        logic update;    // update sums, fill count, pointer; write ring
        logic div_load;  // load dividers with rounded numerator and 2*n
        logic div_step;  // one restoring division step on all lanes
        logic out_load;  // move quotients to output registers
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_last;  // current step is the final quotient bit
    } dp_status_t;

endpackage

`default_nettype wire

### rtl/four_channel_moving_average.sv
// An accepted sample runs through the update, divider load, divide and output
// states, and no new sample is taken before these end; the 16-step restoring
// divider (one quotient bit per cycle, four channel lanes) does the divide.
// A new sample is accepted while the previous result waits at the output.
// Reset (rst_n, async, active low): window length 5, sums, fill count and write
// pointer zero; the ring store is not cleared and no unwritten slot's data is used.
`default_nettype none

module four_channel_moving_average #(
    parameter int WINDOW_MAX = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          window_length_we,
    input  wire logic [fcma_pkg::COUNT_W-1:0]  window_length,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [fcma_pkg::SAMPLE_W-1:0] co_sample,
    input  wire logic [fcma_pkg::SAMPLE_W-1:0] nox_sample,
    input  wire logic [fcma_pkg::SAMPLE_W-1:0] hc_sample,
    input  wire logic [fcma_pkg::SAMPLE_W-1:0] co2_sample,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [fcma_pkg::SAMPLE_W-1:0] co_mean,
    output logic      [fcma_pkg::SAMPLE_W-1:0] nox_mean,
    output logic      [fcma_pkg::SAMPLE_W-1:0] hc_mean,
    output logic      [fcma_pkg::SAMPLE_W-1:0] co2_mean,
    output logic      [fcma_pkg::COUNT_W-1:0]  samples_held
);

    import fcma_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    fcma_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid)
    );

    fcma_datapath #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .window_length_we (window_length_we),
        .window_length    (window_length),
        .co_sample        (co_sample),
        .nox_sample       (nox_sample),
        .hc_sample        (hc_sample),
        .co2_sample       (co2_sample),
        .co_mean          (co_mean),
        .nox_mean         (nox_mean),
        .hc_mean          (hc_mean),
        .co2_mean         (co2_mean),
        .samples_held     (samples_held)
    );

    // A transaction takes the block busy for its whole computation
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while previous sample still in progress");

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || out_ready))
        else $error("output registers loaded over an untaken result");

    // Commands are issued one at a time
    a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.update, cmd.div_load, cmd.div_step, cmd.out_load}))
        else $error("more than one datapath command in a cycle");

    // Every mean is taken over at least one sample
    a_held_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (samples_held != '0))
        else $error("result presented with zero samples held");

endmodule

`default_nettype wire

### rtl/fcma_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module fcma_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/fcma_ctrl.sv
// Sequencing state machine for the moving average block.
`default_nettype none

module fcma_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                out_ready,
    input  wire fcma_pkg::dp_status_t status,
    output fcma_pkg::dp_cmd_t        cmd,
    output logic                     in_ready,
    output logic                     out_valid
);

    import fcma_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                cmd.update = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // hold the result until the previous one is taken
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### rtl/fcma_datapath.sv
// Datapath: sample ring, running sums and four restoring dividers.
`default_nettype none

module fcma_datapath #(
    parameter int WINDOW_MAX = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire fcma_pkg::dp_cmd_t                     cmd,
    output fcma_pkg::dp_status_t                       status,
    input  wire logic                                  window_length_we,
    input  wire logic [fcma_pkg::COUNT_W-1:0]          window_length,
    input  wire logic [fcma_pkg::SAMPLE_W-1:0]         co_sample,
    input  wire logic [fcma_pkg::SAMPLE_W-1:0]         nox_sample,
    input  wire logic [fcma_pkg::SAMPLE_W-1:0]         hc_sample,
    input  wire logic [fcma_pkg::SAMPLE_W-1:0]         co2_sample,
    output logic      [fcma_pkg::SAMPLE_W-1:0]         co_mean,
    output logic      [fcma_pkg::SAMPLE_W-1:0]         nox_mean,
    output logic      [fcma_pkg::SAMPLE_W-1:0]         hc_mean,
    output logic      [fcma_pkg::SAMPLE_W-1:0]         co2_mean,
    output logic      [fcma_pkg::COUNT_W-1:0]          samples_held
);

    import fcma_pkg::*;

    localparam int PTR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int EXT_W  = PTR_W + 2;
    localparam int CNT_MAX = (1 << COUNT_W) - 1;
    localparam int WL_CAP = (WINDOW_MAX < CNT_MAX) ? WINDOW_MAX : CNT_MAX;
    localparam int SUM_W  = SAMPLE_W + $clog2(WL_CAP);
    localparam int NUM_W  = SUM_W + 1;

    // Control state
    logic [COUNT_W-1:0] wl_reg;
    logic [COUNT_W-1:0] wl_next;
    logic [COUNT_W-1:0] fill_reg;
    logic [COUNT_W-1:0] fill_next;
    logic [PTR_W-1:0]   wp_reg;
    logic [PTR_W-1:0]   wp_next;
    logic [SUM_W-1:0]   sum_reg  [CHANNELS];
    logic [SUM_W-1:0]   sum_next [CHANNELS];
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;

    // Payload
    logic [SAMPLE_W-1:0] samp_reg [CHANNELS];
    logic [DEN_W-1:0]    den_reg;
    logic [REM_W-1:0]    rem_reg  [CHANNELS];
    logic [QUO_W-1:0]    quo_reg  [CHANNELS];
    logic [SAMPLE_W-1:0] mean_reg [CHANNELS];
    logic [COUNT_W-1:0]  held_reg;

    logic                full;
    logic [EXT_W-1:0]    wp_ext;
    logic [EXT_W-1:0]    wl_ext;
    logic [EXT_W-1:0]    oldest_ext;
    logic [PTR_W-1:0]    oldest;
    logic [RING_W-1:0]   ring_wdata;
    logic [RING_W-1:0]   ring_rdata;

    assign full = (fill_reg >= wl_reg);

    // Slot of the sample leaving the window
    assign wp_ext     = EXT_W'(wp_reg);
    assign wl_ext     = EXT_W'(wl_reg);
    assign oldest_ext = (wp_ext >= wl_ext) ? (wp_ext - wl_ext)
                                           : (wp_ext + EXT_W'(WINDOW_MAX) - wl_ext);
    assign oldest     = oldest_ext[PTR_W-1:0];

    assign ring_wdata = {samp_reg[3], samp_reg[2], samp_reg[1], samp_reg[0]};

    fcma_ram #(
        .WIDTH (RING_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.update),
        .waddr (wp_reg),
        .wdata (ring_wdata),
        .re    (cmd.capture),
        .raddr (oldest),
        .rdata (ring_rdata)
    );

    // Window length write: saturate to 1..WL_CAP
    always_comb
    begin
        if (window_length == '0)
        begin
            wl_next = COUNT_W'(1);
        end
        else if (window_length > COUNT_W'(WL_CAP))
        begin
            wl_next = COUNT_W'(WL_CAP);
        end
        else
        begin
            wl_next = window_length;
        end
    end

    // History update: sums, fill count, write pointer; all cleared on a length write
    always_comb
    begin
        fill_next = fill_reg;
        wp_next   = wp_reg;
        for (int c = 0; c < CHANNELS; c++)
        begin
            sum_next[c] = sum_reg[c];
        end
        if (window_length_we)
        begin
            fill_next = '0;
            wp_next   = '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                sum_next[c] = '0;
            end
        end
        else if (cmd.update)
        begin
            fill_next = full ? fill_reg : fill_reg + COUNT_W'(1);
            wp_next   = (wp_reg == PTR_W'(WINDOW_MAX - 1)) ? '0 : wp_reg + PTR_W'(1);
            for (int c = 0; c < CHANNELS; c++)
            begin
                sum_next[c] = sum_reg[c] + SUM_W'(samp_reg[c])
                            - (full ? SUM_W'(ring_rdata[c*SAMPLE_W +: SAMPLE_W])
                                    : SUM_W'(0));
            end
        end
    end

    // Division step counter
    always_comb
    begin
        step_next = step_reg;
        if (cmd.div_load)
        begin
            step_next = '0;
        end
        else if (cmd.div_step)
        begin
            step_next = step_reg + STEP_W'(1);
        end
    end

    assign status.div_last = (step_reg == STEP_W'(QUO_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg   <= COUNT_W'(WL_RESET < WL_CAP ? WL_RESET : WL_CAP);
            fill_reg <= '0;
            wp_reg   <= '0;
            step_reg <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                sum_reg[c] <= '0;
            end
        end
        else
        begin
            if (window_length_we)
            begin
                wl_reg <= wl_next;
            end
            fill_reg <= fill_next;
            wp_reg   <= wp_next;
            step_reg <= step_next;
            for (int c = 0; c < CHANNELS; c++)
            begin
                sum_reg[c] <= sum_next[c];
            end
        end
    end

    // Sample capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            samp_reg[0] <= co_sample;
            samp_reg[1] <= nox_sample;
            samp_reg[2] <= hc_sample;
            samp_reg[3] <= co2_sample;
        end
    end

    // Restoring dividers: quotient = (2*sum + n) / (2*n), one bit per step
    always_ff @(posedge clk)
    begin
        logic [NUM_W-1:0] num;
        logic [REM_W-1:0] trial;
        logic             ge;
        if (cmd.div_load)
        begin
            den_reg <= {fill_reg, 1'b0};
            for (int c = 0; c < CHANNELS; c++)
            begin
                num        = {sum_reg[c], 1'b0} + NUM_W'(fill_reg);
                rem_reg[c] <= REM_W'(num[NUM_W-1:QUO_W]);
                quo_reg[c] <= num[QUO_W-1:0];
            end
        end
        else if (cmd.div_step)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                trial      = {rem_reg[c][REM_W-2:0], quo_reg[c][QUO_W-1]};
                ge         = (trial >= REM_W'(den_reg));
                rem_reg[c] <= ge ? (trial - REM_W'(den_reg)) : trial;
                quo_reg[c] <= {quo_reg[c][QUO_W-2:0], ge};
            end
        end
    end

    // Output registers
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                mean_reg[c] <= quo_reg[c];
            end
            held_reg <= fill_reg;
        end
    end

    assign co_mean      = mean_reg[0];
    assign nox_mean     = mean_reg[1];
    assign hc_mean      = mean_reg[2];
    assign co2_mean     = mean_reg[3];
    assign samples_held = held_reg;

endmodule

`default_nettype wire

### sim/tb.sv
// Testbench for the four-channel moving average: scoreboard class, drivers and checks.
`timescale 1ns / 1ps

module tb;
    import fcma_pkg::*;

    localparam int WINDOW_MAX     = 32;
    localparam int HOLD_OFF       = 400;   // long receiver stall, in cycles
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction at all
    localparam int PRINT_LIMIT    = 40;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 70;

    typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] sample_t;  // [0]=co .. [3]=co2

    typedef struct packed {
        sample_t              chan;
        logic [COUNT_W-1:0]   held;
    } mean_t;

    // Running-sum model of the filter plus the queue of means still owed
    class mean_scoreboard;
        sample_t     ring [WINDOW_MAX];
        int unsigned chan_sum [CHANNELS];
        int unsigned held;
        int unsigned slot;
        int unsigned window;
        mean_t       owed_q [$];
        string       label [CHANNELS];

        function new();
            foreach (ring[i]) ring[i] = '0;
            label = '{"co", "nox", "hc", "co2"};
            window = WL_RESET;
            clear();
        endfunction

        function void clear();
            foreach (chan_sum[c]) chan_sum[c] = 0;
            held = 0;
            slot = 0;
        endfunction

        // Zero is stored as 1, anything above the store depth saturates
        function void set_window(logic [COUNT_W-1:0] value);
            int unsigned w;
            w = value;
            if (w == 0)
                w = 1;
            if (w > WINDOW_MAX)
                w = WINDOW_MAX;
            window = w;
            clear();
        endfunction

        // Round half up: floor((2*sum + n) / (2*n))
        function logic [SAMPLE_W-1:0] rounded_div(int unsigned sum, int unsigned n);
            longint unsigned q;
            q = (2 * longint'(sum) + longint'(n)) / (2 * longint'(n));
            return q[SAMPLE_W-1:0];
        endfunction

        function void note_sample(sample_t s);
            int unsigned oldest;
            mean_t m;
            if (held >= window)
            begin
                // window full: retire the oldest sample
                oldest = (slot + WINDOW_MAX - window) % WINDOW_MAX;
                for (int c = 0; c < CHANNELS; c++)
                    chan_sum[c] -= ring[oldest][c];
            end
            else
                held++;
            ring[slot] = s;
            for (int c = 0; c < CHANNELS; c++)
                chan_sum[c] += s[c];
            slot = (slot + 1) % WINDOW_MAX;
            for (int c = 0; c < CHANNELS; c++)
                m.chan[c] = rounded_div(chan_sum[c], held);
            m.held = held[COUNT_W-1:0];
            owed_q = {owed_q, m};
        endfunction

        // Returns 1 when the result matches the oldest owed mean
        function bit check_result(mean_t got, output string why);
            mean_t want;
            why = "";
            if (owed_q.size() == 0)
            begin
                why = $sformatf("result with no sample outstanding: %h", got);
                return 0;
            end
            want = owed_q.pop_front();
            for (int c = 0; c < CHANNELS; c++)
                if (got.chan[c] != want.chan[c])
                    why = {why, $sformatf(" %s_mean got %h want %h",
                                          label[c], got.chan[c], want.chan[c])};
            if (got.held != want.held)
                why = {why, $sformatf(" samples_held got %0d want %0d",
                                      got.held, want.held)};
            return why == "";
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                window_length_we;
    logic [COUNT_W-1:0]  window_length;
    logic                in_valid;
    logic                in_ready;
    logic [SAMPLE_W-1:0] co_sample;
    logic [SAMPLE_W-1:0] nox_sample;
    logic [SAMPLE_W-1:0] hc_sample;
    logic [SAMPLE_W-1:0] co2_sample;
    logic                out_valid;
    logic                out_ready;
    logic [SAMPLE_W-1:0] co_mean;
    logic [SAMPLE_W-1:0] nox_mean;
    logic [SAMPLE_W-1:0] hc_mean;
    logic [SAMPLE_W-1:0] co2_mean;
    logic [COUNT_W-1:0]  samples_held;

    mean_scoreboard sb;
    int  fail_count;
    int  quiet_cycles;
    int  sender_gap_max;
    int  receiver_gap_max;
    bit  hold_off_req;

    four_channel_moving_average #(
        .WINDOW_MAX(WINDOW_MAX)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .window_length_we (window_length_we),
        .window_length    (window_length),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .co_sample        (co_sample),
        .nox_sample       (nox_sample),
        .hc_sample        (hc_sample),
        .co2_sample       (co2_sample),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .co_mean          (co_mean),
        .nox_mean         (nox_mean),
        .hc_mean          (hc_mean),
        .co2_mean         (co2_mean),
        .samples_held     (samples_held)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report(input string msg);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("tb: mismatch %0d:%s", fail_count, msg);
    endtask

    // Transaction monitor: config writes, accepted samples, accepted results
    always @(posedge clk)
    begin : txn_monitor
        string why;
        mean_t got;
        if (rst_n)
        begin
            if (window_length_we)
                sb.set_window(window_length);
            if (in_valid && in_ready)
                sb.note_sample({co2_sample, hc_sample, nox_sample, co_sample});
            if (out_valid && out_ready)
            begin
                got.chan = {co2_mean, hc_mean, nox_mean, co_mean};
                got.held = samples_held;
                if (!sb.check_result(got, why))
                    report(why);
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || window_length_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Receiver: random stalls per result, one long hold-off on request
    initial
    begin : receiver
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = $urandom_range(0, receiver_gap_max);
            if (hold_off_req)
            begin
                stall = HOLD_OFF;
                hold_off_req = 1'b0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Offer one sample after a random gap; returns at the accepting edge
    task automatic send_sample(input logic [SAMPLE_W-1:0] co, input logic [SAMPLE_W-1:0] nox,
                               input logic [SAMPLE_W-1:0] hc, input logic [SAMPLE_W-1:0] co2);
        int gap;
        gap = $urandom_range(0, sender_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        co_sample  <= co;
        nox_sample <= nox;
        hc_sample  <= hc;
        co2_sample <= co2;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stop offering and wait until every owed mean has come out
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_window(input logic [COUNT_W-1:0] value);
        window_length    <= value;
        window_length_we <= 1'b1;
        @(posedge clk);
        window_length_we <= 1'b0;
        @(posedge clk);
    endtask

    // Reading generator; heavy pushes toward full scale to load the sums
    function automatic logic [SAMPLE_W-1:0] pick_reading(input bit heavy);
        if (heavy && $urandom_range(0, 3) != 0)
            return '1;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return SAMPLE_W'($urandom_range(0, 3));
            3: return ~SAMPLE_W'($urandom_range(0, 3));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Main sequence
    initial
    begin
        logic [COUNT_W-1:0] phase_window [PHASES];
        bit heavy;

        sb = new();
        fail_count       = 0;
        quiet_cycles     = 0;
        hold_off_req     = 1'b0;
        sender_gap_max   = 6;
        receiver_gap_max = 6;
        rst_n            <= 1'b0;
        window_length_we <= 1'b0;
        window_length    <= COUNT_W'(WL_RESET);
        in_valid         <= 1'b0;
        co_sample        <= '0;
        nox_sample       <= '0;
        hc_sample        <= '0;
        co2_sample       <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset window, wrap of a short window, extremes, rounding
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_sample(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_sample(16'h0001, 16'h0000, 16'hffff, 16'h8000);
        send_sample(16'h0000, 16'h0001, 16'h0002, 16'h0003);
        send_sample(16'h5555, 16'haaaa, 16'h7fff, 16'h8000);
        send_sample(16'hffff, 16'h0000, 16'hffff, 16'h0000);
        send_sample(16'h0001, 16'h0001, 16'h0001, 16'h0001);
        send_sample(16'h0000, 16'hffff, 16'h0000, 16'hffff);
        send_sample(16'h0002, 16'h0003, 16'h0004, 16'h0005);
        drain();
        // window of one passes the sample through
        set_window(6'd1);
        send_sample(16'hffff, 16'h0000, 16'h1234, 16'h8001);
        send_sample(16'h0000, 16'hffff, 16'h0000, 16'h0001);
        drain();
        // full depth window, partial fill
        set_window(6'd32);
        send_sample(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_sample(16'h0001, 16'h0000, 16'h0001, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0001);
        drain();
        // zero length is stored as one
        set_window(6'd0);
        send_sample(16'h8000, 16'h7fff, 16'h0001, 16'hfffe);
        send_sample(16'h0003, 16'hfffc, 16'h0000, 16'hffff);
        drain();
        // over-range length saturates to the store depth
        set_window(6'd63);
        send_sample(16'hffff, 16'h0001, 16'h8000, 16'h0000);
        send_sample(16'h0001, 16'hffff, 16'h0000, 16'h8000);
        drain();

        // Random phases over a spread of window settings
        phase_window = '{6'd32, 6'd1, 6'd2, 6'd7, 6'd33, 6'd16, 6'd31, 6'd63, 6'd0,
                         COUNT_W'($urandom_range(0, 63))};
        for (int p = 0; p < PHASES; p++)
        begin
            set_window(phase_window[p]);
            heavy            = (p == 0);
            sender_gap_max   = (p == 2) ? 0 : 6;
            receiver_gap_max = (p == 2 || p == 7) ? 0 : 6;
            if (p == 5)
                hold_off_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_sample(pick_reading(heavy), pick_reading(heavy),
                            pick_reading(heavy), pick_reading(heavy));
            drain();
        end

        // Settle, then look for leftovers and strays
        repeat (25) @(posedge clk);
        if (sb.pending() != 0)
            report($sformatf(" %0d means never came out", sb.pending()));
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
